// ===== rtl/mwrp_pkg.sv =====
// ----------------------------------------------------------------------------
// mwrp_pkg: shared types and codes for the multiset with random pick
// Opcodes, status codes, sequencer states and divider step constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mwrp_pkg;

  // field widths fixed by the item format
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned RND_W  = 31;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;

  // serial divider: one remainder step per quotient bit
  localparam int unsigned DIV_STEPS = 31;
  localparam int unsigned STEP_W    = 5;

  // opcodes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_PICK   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // sequencer states
  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_SCAN      = 8'b0000_0010,
    ST_MOVE_RD   = 8'b0000_0100,
    ST_MOVE_WR   = 8'b0000_1000,
    ST_DIV       = 8'b0001_0000,
    ST_PICK_RD   = 8'b0010_0000,
    ST_PICK_WAIT = 8'b0100_0000,
    ST_RESULT    = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/multiset_with_random_pick_top.sv =====
// ----------------------------------------------------------------------------
// multiset_with_random_pick_top: multiset store with random pick
// Dense store of signed 32-bit values (duplicates allowed) with insert,
// remove (swap last into hole) and pick at random_word modulo entry count.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid / in_stall     | opcode, item_value, random_word
//  out     | output    | out_valid / out_stall   | answer_flag, picked_value, status
//
//  insert and remove walk the store one slot a cycle through the single read
//  port; remove then moves the last entry into the hole it leaves.
//  pick runs a 31-step restoring divider for the modulo, then one read.
//  reset clears the entry count and control state only; no clearing pass over the store.
//  in_stall is high while an item is in work; a result waiting on out_stall
//  holds the next item only once that item has finished its own work.
//
`default_nettype none

module multiset_with_random_pick_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // input channel
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [mwrp_pkg::OP_W-1:0]            in_opcode,
  input  wire  signed [mwrp_pkg::VAL_W-1:0]    in_item_value,
  input  wire  [mwrp_pkg::RND_W-1:0]           in_random_word,
  // result channel
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic                                 out_answer_flag,
  output logic signed [mwrp_pkg::VAL_W-1:0]    out_picked_value,
  output logic [mwrp_pkg::STAT_W-1:0]          out_status
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam int unsigned VW = mwrp_pkg::VAL_W;
  localparam int unsigned RW = mwrp_pkg::RND_W;
  localparam int unsigned SW = mwrp_pkg::STEP_W;

  // store and its registered read port
  logic [VW-1:0] store_r [CAPACITY];
  logic [VW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;

  // control state
  mwrp_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic             out_valid_r, out_valid_nxt;

  // item and work registers
  logic [mwrp_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [VW-1:0]               val_r, val_nxt;
  logic [AW-1:0]               scan_addr_r, scan_addr_nxt;
  logic [CW-1:0]               scan_left_r, scan_left_nxt;
  logic [AW-1:0]               cmp_addr_r, cmp_addr_nxt;
  logic [AW-1:0]               hit_r, hit_nxt;
  logic [CW-1:0]               rem_r, rem_nxt;
  logic [RW-1:0]               quo_r, quo_nxt;
  logic [SW-1:0]               step_r, step_nxt;

  // pending result and output registers
  logic                        res_flag_r, res_flag_nxt;
  logic [VW-1:0]               res_picked_r, res_picked_nxt;
  logic [mwrp_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic                        out_flag_r, out_flag_nxt;
  logic [VW-1:0]               out_picked_r, out_picked_nxt;
  logic [mwrp_pkg::STAT_W-1:0] out_status_r, out_status_nxt;

  // shared compare and subtract
  logic          found;
  logic [CW:0]   rem_shift;
  logic [CW:0]   rem_diff;

  assign found     = cmp_vld_r && (rd_data_r == val_r);
  assign rem_shift = {rem_r, quo_r[RW-1]};
  assign rem_diff  = rem_shift - {1'b0, count_r};

  assign in_stall         = (state_r != mwrp_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_answer_flag  = out_flag_r;
  assign out_picked_value = out_picked_r;
  assign out_status       = out_status_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cmp_vld_nxt    = cmp_vld_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    scan_addr_nxt  = scan_addr_r;
    scan_left_nxt  = scan_left_r;
    cmp_addr_nxt   = cmp_addr_r;
    hit_nxt        = hit_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    step_nxt       = step_r;
    res_flag_nxt   = res_flag_r;
    res_picked_nxt = res_picked_r;
    res_status_nxt = res_status_r;
    out_flag_nxt   = out_flag_r;
    out_picked_nxt = out_picked_r;
    out_status_nxt = out_status_r;
    rd_addr        = scan_addr_r;
    wr_en          = 1'b0;
    wr_addr        = count_r[AW-1:0];
    wr_data        = val_r;

    // output register drains on transfer
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      mwrp_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_opcode;
          val_nxt        = in_item_value;
          quo_nxt        = in_random_word;
          rem_nxt        = '0;
          step_nxt       = SW'(mwrp_pkg::DIV_STEPS - 1);
          scan_left_nxt  = count_r;
          scan_addr_nxt  = (in_opcode == mwrp_pkg::OP_INSERT) ? '0
                                                              : AW'(count_r - 1'b1);
          cmp_vld_nxt    = 1'b0;
          res_flag_nxt   = 1'b0;
          res_picked_nxt = '0;
          res_status_nxt = mwrp_pkg::STAT_OK;
          unique case (in_opcode)
            mwrp_pkg::OP_INSERT: begin
              if (count_r == CAP_CNT) begin
                res_status_nxt = mwrp_pkg::STAT_FULL;
                state_nxt      = mwrp_pkg::ST_RESULT;
              end else begin
                state_nxt = mwrp_pkg::ST_SCAN;
              end
            end
            mwrp_pkg::OP_REMOVE: begin
              state_nxt = mwrp_pkg::ST_SCAN;
            end
            mwrp_pkg::OP_PICK: begin
              if (count_r == '0) begin
                res_status_nxt = mwrp_pkg::STAT_EMPTY;
                state_nxt      = mwrp_pkg::ST_RESULT;
              end else begin
                state_nxt = mwrp_pkg::ST_DIV;
              end
            end
            default: begin
              state_nxt = mwrp_pkg::ST_RESULT;
            end
          endcase
        end
      end

      // one slot read and one compare per cycle, the compare works on the registered read data
      mwrp_pkg::ST_SCAN: begin
        if (found || scan_left_r == '0) begin
          cmp_vld_nxt = 1'b0;
          if (op_r == mwrp_pkg::OP_INSERT) begin
            res_flag_nxt = !found;
            wr_en        = 1'b1;
            count_nxt    = count_r + 1'b1;
            state_nxt    = mwrp_pkg::ST_RESULT;
          end else if (found) begin
            res_flag_nxt = 1'b1;
            hit_nxt      = cmp_addr_r;
            state_nxt    = mwrp_pkg::ST_MOVE_RD;
          end else begin
            state_nxt = mwrp_pkg::ST_RESULT;
          end
        end else begin
          cmp_vld_nxt   = 1'b1;
          cmp_addr_nxt  = scan_addr_r;
          scan_left_nxt = scan_left_r - 1'b1;
          scan_addr_nxt = (op_r == mwrp_pkg::OP_INSERT) ? scan_addr_r + 1'b1
                                                        : scan_addr_r - 1'b1;
        end
      end

      // fetch the last entry
      mwrp_pkg::ST_MOVE_RD: begin
        rd_addr   = AW'(count_r - 1'b1);
        state_nxt = mwrp_pkg::ST_MOVE_WR;
      end

      // last entry fills the hole and the store shrinks
      mwrp_pkg::ST_MOVE_WR: begin
        wr_en     = 1'b1;
        wr_addr   = hit_r;
        wr_data   = rd_data_r;
        count_nxt = count_r - 1'b1;
        state_nxt = mwrp_pkg::ST_RESULT;
      end

      // restoring division, one quotient bit per cycle, remainder only
      mwrp_pkg::ST_DIV: begin
        rem_nxt  = rem_diff[CW] ? rem_shift[CW-1:0] : rem_diff[CW-1:0];
        quo_nxt  = {quo_r[RW-2:0], 1'b0};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = mwrp_pkg::ST_PICK_RD;
        end
      end

      mwrp_pkg::ST_PICK_RD: begin
        rd_addr   = rem_r[AW-1:0];
        state_nxt = mwrp_pkg::ST_PICK_WAIT;
      end

      mwrp_pkg::ST_PICK_WAIT: begin
        res_picked_nxt = rd_data_r;
        state_nxt      = mwrp_pkg::ST_RESULT;
      end

      // hand the result to the output register once it is free
      mwrp_pkg::ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_flag_nxt   = res_flag_r;
          out_picked_nxt = res_picked_r;
          out_status_nxt = res_status_r;
          state_nxt      = mwrp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mwrp_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mwrp_pkg::ST_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // work and result registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    scan_addr_r  <= scan_addr_nxt;
    scan_left_r  <= scan_left_nxt;
    cmp_addr_r   <= cmp_addr_nxt;
    hit_r        <= hit_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    step_r       <= step_nxt;
    res_flag_r   <= res_flag_nxt;
    res_picked_r <= res_picked_nxt;
    res_status_r <= res_status_nxt;
    out_flag_r   <= out_flag_nxt;
    out_picked_r <= out_picked_nxt;
    out_status_r <= out_status_nxt;
  end

  // store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
    rd_data_r <= store_r[rd_addr];
  end

  // entry count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  // divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mwrp_pkg::ST_DIV) |-> (rem_r < count_r))
    else $error("divider remainder not below entry count");

  // the hole being filled lies inside the store
  a_hit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mwrp_pkg::ST_MOVE_WR) |-> ({1'b0, hit_r} < (AW + 1)'(count_r)))
    else $error("remove slot outside the store");

  // one item moves the count by at most one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) ||
                      count_r == $past(count_r) + 1'b1 ||
                      count_r == $past(count_r) - 1'b1))
    else $error("entry count jumped");

endmodule

`default_nettype wire
